[rtl/core/shfc_pkg.sv]
// ----------------------------------------------------------------------------
// shfc_pkg
// Shared types and constants of the single/half float converter.
// ----------------------------------------------------------------------------
`default_nettype none
package shfc_pkg;

   // Conversion direction codes.
   localparam logic FUNC_S2H = 1'b0;
   localparam logic FUNC_H2S = 1'b1;

   // Half-precision special patterns.
   localparam logic [14:0] HALF_INF  = 15'h7C00;
   localparam logic [14:0] HALF_QNAN = 15'h7E00;

   // Stage one result, carried to stage two.
   typedef struct packed {
      logic        func;
      logic        sign;
      logic        s2h_zero;
      logic        s2h_nan;
      logic        s2h_inf;
      logic        s2h_sub;
      logic [23:0] s2h_mant;
      logic [4:0]  s2h_shift;
      logic [4:0]  s2h_exp;
      logic [4:0]  h2s_exp;
      logic [9:0]  h2s_mant;
   } stage1_type;

   // Stage two result, carried to stage three.
   typedef struct packed {
      logic        func;
      logic        sign;
      logic        s2h_special;
      logic [14:0] s2h_special_val;
      logic [14:0] s2h_base;
      logic        s2h_round;
      logic        h2s_zero;
      logic        h2s_sub;
      logic        h2s_inf;
      logic [4:0]  h2s_exp;
      logic [9:0]  h2s_mant;
      logic [3:0]  h2s_lz;
   } stage2_type;

endpackage
`default_nettype wire

[rtl/core/single_half_float_convert.sv]
// ----------------------------------------------------------------------------
// single_half_float_convert
// Converts IEEE binary32 to binary16 or back, direction chosen per item.
// ----------------------------------------------------------------------------
// Channel   Ports                                   Direction
// request   start, busy, req_func, req_operand_bits input
// response  rsp_valid, rsp_result_bits              output
//
// Each item runs through the pipeline from start to the rsp_valid strobe.
// A new item is taken every cycle; busy is tied low.
// The latency is set by three register stages: decode, shift/count, round/pack.
// Synchronous reset clears the valid bits only.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none
module single_half_float_convert (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_func,
   input  wire logic [31:0] req_operand_bits,
   output logic             rsp_valid,
   output logic [31:0]      rsp_result_bits
);

   shfc_pkg::stage1_type s1_in, s1_ff;
   shfc_pkg::stage2_type s2_in, s2_ff;
   logic        v1_ff, v2_ff, v3_ff;
   logic [31:0] res_in, res_ff;

   assign busy = 1'b0;

   // Stage one: field decode and class flags.
   always_comb begin
      logic [7:0] ef;
      logic [4:0] he;
      logic [8:0] e;
      ef = req_operand_bits[30:23];
      he = req_operand_bits[14:10];
      e  = {1'b0, ef} - 9'd112;
      s1_in           = '0;
      s1_in.func      = req_func;
      s1_in.sign      = (req_func == shfc_pkg::FUNC_S2H) ? req_operand_bits[31]
                                                         : req_operand_bits[15];
      s1_in.s2h_mant  = {1'b1, req_operand_bits[22:0]};
      // e <= 0 when ef <= 112; below -10 when ef < 102.
      s1_in.s2h_zero  = (ef < 8'd102);
      s1_in.s2h_sub   = (ef <= 8'd112);
      s1_in.s2h_shift = 5'(9'd126 - {1'b0, ef});
      s1_in.s2h_nan   = (ef == 8'hFF) && (req_operand_bits[22:0] != '0);
      s1_in.s2h_inf   = (ef >= 8'd143);
      s1_in.s2h_exp   = e[4:0];
      s1_in.h2s_exp   = he;
      s1_in.h2s_mant  = req_operand_bits[9:0];
   end

   // Stage two: subnormal shift, nearest rounding bit, leading-zero count.
   always_comb begin
      logic [23:0] hm;
      logic [23:0] rb;
      logic [3:0]  lz;
      hm = s1_ff.s2h_mant >> s1_ff.s2h_shift;
      rb = s1_ff.s2h_mant >> (s1_ff.s2h_shift - 5'd1);
      lz = 4'd10;
      for (int i = 0; i < 10; i++) begin
         if (s1_ff.h2s_mant[i]) lz = 4'(9 - i);
      end
      s2_in                 = '0;
      s2_in.func            = s1_ff.func;
      s2_in.sign            = s1_ff.sign;
      s2_in.h2s_exp         = s1_ff.h2s_exp;
      s2_in.h2s_mant        = s1_ff.h2s_mant;
      s2_in.h2s_lz          = lz;
      s2_in.h2s_zero        = (s1_ff.h2s_exp == '0) && (s1_ff.h2s_mant == '0);
      s2_in.h2s_sub         = (s1_ff.h2s_exp == '0);
      s2_in.h2s_inf         = (s1_ff.h2s_exp == 5'h1F);
      if (s1_ff.s2h_zero) begin
         s2_in.s2h_special     = 1'b1;
         s2_in.s2h_special_val = '0;
      end else if (s1_ff.s2h_sub) begin
         s2_in.s2h_base  = {5'd0, hm[9:0]};
         s2_in.s2h_round = rb[0];
      end else if (s1_ff.s2h_nan) begin
         s2_in.s2h_special     = 1'b1;
         s2_in.s2h_special_val = shfc_pkg::HALF_QNAN;
      end else if (s1_ff.s2h_inf) begin
         s2_in.s2h_special     = 1'b1;
         s2_in.s2h_special_val = shfc_pkg::HALF_INF;
      end else begin
         s2_in.s2h_base  = {s1_ff.s2h_exp, s1_ff.s2h_mant[22:13]};
         s2_in.s2h_round = s1_ff.s2h_mant[12];
      end
   end

   // Stage three: round and pack. A carry into exponent 31 lands exactly on
   // the infinity pattern, so the plain increment already saturates.
   always_comb begin
      logic [14:0] sum;
      logic [9:0]  nm;
      logic [7:0]  ne;
      sum = s2_ff.s2h_base + 15'(s2_ff.s2h_round);
      nm  = 10'(s2_ff.h2s_mant << (s2_ff.h2s_lz + 4'd1));
      ne  = 8'd113 - 8'(s2_ff.h2s_lz) - 8'd1;
      if (s2_ff.func == shfc_pkg::FUNC_S2H) begin
         res_in = {16'd0, s2_ff.sign,
                   s2_ff.s2h_special ? s2_ff.s2h_special_val : sum};
      end else if (s2_ff.h2s_zero) begin
         res_in = {s2_ff.sign, 31'd0};
      end else if (s2_ff.h2s_sub) begin
         res_in = {s2_ff.sign, ne, nm, 13'd0};
      end else if (s2_ff.h2s_inf) begin
         res_in = {s2_ff.sign, 8'hFF, s2_ff.h2s_mant, 13'd0};
      end else begin
         res_in = {s2_ff.sign, 8'(s2_ff.h2s_exp) + 8'd112, s2_ff.h2s_mant, 13'd0};
      end
   end

   // Pipeline registers; valid bits are the only reset state.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      s1_ff  <= s1_in;
      s2_ff  <= s2_in;
      res_ff <= res_in;
   end

   assign rsp_valid       = v3_ff;
   assign rsp_result_bits = res_ff;

   // A half result never has upper bits set.
   a_half_upper: assert property (@(posedge clock) disable iff (reset)
      v2_ff && s2_ff.func == shfc_pkg::FUNC_S2H |=> res_ff[31:16] == 16'd0)
      else $error("half result has upper bits set");

   // Every accepted item comes out as an rsp_valid strobe.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |=> ##2 rsp_valid)
      else $error("item lost in pipeline");

   // Nothing comes out without a prior item.
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(v2_ff))
      else $error("result without item");

endmodule
`default_nettype wire

[bench/single_half_float_convert_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_half_float_convert_test
// Self-checking bench for the single/half float converter. Directed items hit
// zeros, subnormals, infinity and NaN in both directions and rounding carries
// and overflow when narrowing, then random items cover the exponent ranges.
// Every result is checked against an internal predictor in arrival order.
// ----------------------------------------------------------------------------
module single_half_float_convert_test;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_func = shfc_pkg::FUNC_S2H;
   logic [31:0] req_operand_bits = '0;
   logic        rsp_valid;
   logic [31:0] rsp_result_bits;

   logic [31:0] expected_bits_q[$];
   int          error_count = 0;
   int          idle_cycles = 0;
   localparam int IDLE_LIMIT = 200;
   localparam int DRAIN_CYCLES = 10;

   single_half_float_convert dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_operand_bits(req_operand_bits),
      .rsp_valid(rsp_valid), .rsp_result_bits(rsp_result_bits)
   );

   always #5 clock = ~clock;

   // Single to half, rounding half up on the first dropped bit.
   function automatic logic [31:0] narrow_to_half(logic [31:0] x);
      logic [15:0] sgn;
      logic [23:0] man;
      logic [7:0]  ef;
      int          ex;
      int          sh;
      logic [15:0] hm;
      logic [15:0] hexp;
      sgn = {x[31], 15'd0};
      man = {1'b0, x[22:0]};
      ef  = x[30:23];
      ex  = int'(ef) - 112;
      if (ex <= 0) begin
         if (ex < -10) return {16'd0, sgn};
         man[23] = 1'b1;
         sh = 14 - ex;
         hm = 16'(man >> sh) + 16'((man >> (sh - 1)) & 1);
         return {16'd0, sgn | hm};
      end
      if (ef == 8'hFF && man != 0) return {16'd0, sgn | {1'b0, shfc_pkg::HALF_QNAN}};
      if (ex >= 31) return {16'd0, sgn | {1'b0, shfc_pkg::HALF_INF}};
      hexp = 16'(ex) << 10;
      hm = 16'(man[22:13]);
      if (man[12]) begin
         hm++;
         if (hm == 16'h0400) begin
            hm = 0;
            hexp += 16'h0400;
            if (hexp >= 16'h7C00) return {16'd0, sgn | {1'b0, shfc_pkg::HALF_INF}};
         end
      end
      return {16'd0, sgn | hexp | hm};
   endfunction

   // Half to single, exact; subnormals are normalized.
   function automatic logic [31:0] widen_to_single(logic [15:0] h);
      logic [4:0]  ex;
      logic [10:0] man;
      int          k;
      ex = h[14:10];
      man = {1'b0, h[9:0]};
      k = 0;
      if (ex == 0) begin
         if (man == 0) return {h[15], 31'd0};
         while (!man[10]) begin
            man = man << 1;
            k++;
         end
         return {h[15], 8'(113 - k), man[9:0], 13'd0};
      end
      if (ex == 5'h1F) return {h[15], 8'hFF, h[9:0], 13'd0};
      return {h[15], 8'(ex + 112), h[9:0], 13'd0};
   endfunction

   // Compare each result with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_bits_q.size() == 0) begin
            $error("result_bits: no item pending, actual %h", rsp_result_bits);
            error_count++;
         end else begin
            logic [31:0] want;
            want = expected_bits_q.pop_front();
            if (rsp_result_bits !== want) begin
               $error("result_bits: expected %h actual %h", want, rsp_result_bits);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles with no accepted item or result.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("single_half_float_convert regression: fail");
         $finish;
      end
   end

   // Send one item, after a random gap when gaps is set; start stays high across back-to-back items.
   task automatic send_item(logic fn, logic [31:0] bits, bit gaps = 1);
      int gap;
      gap = gaps ? $urandom_range(0, 8) : 0;
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_func <= fn;
      req_operand_bits <= bits;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_bits_q.push_back(fn == shfc_pkg::FUNC_S2H ? narrow_to_half(bits)
                                                         : widen_to_single(bits[15:0]));
   endtask

   task automatic wait_drained();
      while (expected_bits_q.size() != 0) @(posedge clock);
   endtask

   // Directed single-to-half corners.
   task automatic test_narrow_corners();
      send_item(shfc_pkg::FUNC_S2H, 32'h0000_0000);
      send_item(shfc_pkg::FUNC_S2H, 32'h8000_0001);   // single subnormal
      send_item(shfc_pkg::FUNC_S2H, 32'h3300_0000);   // 2^-25, rounds to smallest subnormal
      send_item(shfc_pkg::FUNC_S2H, 32'hB2FF_FFFF);   // below subnormal range
      send_item(shfc_pkg::FUNC_S2H, 32'h387F_F000);   // subnormal carry into smallest normal
      send_item(shfc_pkg::FUNC_S2H, 32'h3F80_0000);
      send_item(shfc_pkg::FUNC_S2H, 32'h3FFF_F000);   // mantissa carry into exponent
      send_item(shfc_pkg::FUNC_S2H, 32'h477F_F000);   // carry past largest half
      send_item(shfc_pkg::FUNC_S2H, 32'hC77F_EFFF);   // largest half, no carry
      send_item(shfc_pkg::FUNC_S2H, 32'h4780_0000);   // too large
      send_item(shfc_pkg::FUNC_S2H, 32'h7F7F_FFFF);
      send_item(shfc_pkg::FUNC_S2H, 32'h7F80_0000);
      send_item(shfc_pkg::FUNC_S2H, 32'hFF80_0001);   // NaN, sign kept
      send_item(shfc_pkg::FUNC_S2H, 32'hFFFF_FFFF);
   endtask

   // Directed half-to-single corners, with junk in the ignored upper bits.
   task automatic test_widen_corners();
      send_item(shfc_pkg::FUNC_H2S, 32'hFFFF_0000);
      send_item(shfc_pkg::FUNC_H2S, 32'h0000_8001);
      send_item(shfc_pkg::FUNC_H2S, 32'h1234_03FF);
      send_item(shfc_pkg::FUNC_H2S, 32'h0000_0200);
      send_item(shfc_pkg::FUNC_H2S, 32'h0000_0400);
      send_item(shfc_pkg::FUNC_H2S, 32'h0000_7BFF);
      send_item(shfc_pkg::FUNC_H2S, 32'hA5A5_7C00);
      send_item(shfc_pkg::FUNC_H2S, 32'h0000_FE01);
      send_item(shfc_pkg::FUNC_H2S, 32'h0000_FFFF);
   endtask

   // Random items biased toward the exponents that reach half range.
   task automatic test_random_mix(int count);
      logic [31:0] bits;
      logic        fn;
      for (int i = 0; i < count; i++) begin
         bits = $urandom;
         fn = $urandom_range(0, 1);
         if (fn == shfc_pkg::FUNC_S2H && $urandom_range(0, 3) != 0)
            bits[30:23] = 8'($urandom_range(100, 145));
         if ($urandom_range(0, 15) == 0) bits[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         send_item(fn, bits, i % 200 >= 150);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_narrow_corners();
      test_widen_corners();
      start <= 1'b0;
      wait_drained();
      test_random_mix(1250);
      start <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_bits_q.size() == 0)
         $display("single_half_float_convert regression: pass");
      else
         $display("single_half_float_convert regression: fail");
      $finish;
   end
endmodule

[filelist.f]
rtl/core/shfc_pkg.sv
rtl/core/single_half_float_convert.sv
bench/single_half_float_convert_test.sv
